// ===== rtl/vector3_normalize_top_defines.svh =====
// Assertion macros used by the checker file of vector3_normalize_top.
// Depends on nothing; include once per compilation unit.
`ifndef VECTOR3_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR3_NORMALIZE_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define VN_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define VN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vn_pkg.sv =====
// Shared constants for the vector normalizer.
// Depends on nothing.
`timescale 1ns / 1ps

package vn_pkg;
   localparam int IN_WIDTH_DEF  = 16;
   localparam int FRAC_BITS_DEF = 14;
   localparam int EPS_WIDTH     = 15;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);
endpackage

// ===== rtl/vector3_normalize_top.sv =====
// From req word to rsp word the data passes two prep stages, one chain cell per
// quotient bit and one output register.
// Throughput: one word per cycle; the whole pipeline stalls only while rsp is held.
// Reset clears all valid bits and sets zero_epsilon to 1.
// Depends on vn_pkg, vn_prep, vn_cell.
`timescale 1ns / 1ps

module vector3_normalize_top #(
   parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF,
   localparam int OW  = FRAC_BITS + 2,
   localparam int IDW = ((3 * IN_WIDTH + 7) / 8) * 8,
   localparam int ODW = ((3 * OW + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [IDW-1:0]                req_tdata,   // x_in, y_in, z_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ODW-1:0]                rsp_tdata,   // x_out, y_out, z_out
   output logic                          rsp_tuser,   // zero_vector
   input  logic                          csr_tvalid,
   output logic                          csr_tready,
   input  logic [vn_pkg::EPS_WIDTH-1:0]  csr_tdata    // zero_epsilon
);
   localparam int SW = 2 * IN_WIDTH;
   localparam int RW = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;
   localparam int QW = FRAC_BITS + 1;
   localparam int NC = FRAC_BITS + 1;
   localparam int CW = ((QW > vn_pkg::EPS_WIDTH) ? QW : vn_pkg::EPS_WIDTH) + 1;

   logic                            advance;
   logic [2:0][IN_WIDTH-1:0]        comp;
   logic [vn_pkg::EPS_WIDTH-1:0]    eps_ff;
   logic                            rsp_valid_ff;
   logic [2:0][OW-1:0]              res_ff, res_in;
   logic                            zv_ff;

   logic [NC:0]                     c_valid;
   logic [NC:0][SW-1:0]             c_s;
   logic [NC:0][2:0][RW-1:0]        c_r;
   logic [NC:0][2:0][RW-1:0]        c_b;
   logic [NC:0][2:0][QW-1:0]        c_q;
   logic [NC:0][2:0]                c_neg;
   logic [NC:0]                     c_zero;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_tready = 1'b1;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         comp[k] = req_tdata[k*IN_WIDTH +: IN_WIDTH];
      end
   end

   vn_prep #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS)) u_prep (
      .clock(clock), .reset(reset), .advance(advance),
      .valid_in(req_tvalid), .comp_in(comp),
      .valid_out(c_valid[0]), .s_out(c_s[0]), .r_out(c_r[0]),
      .neg_out(c_neg[0]), .zero_out(c_zero[0])
   );
   assign c_b[0] = '0;
   assign c_q[0] = '0;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      vn_cell #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - i)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(c_valid[i]), .s_in(c_s[i]), .r_in(c_r[i]), .b_in(c_b[i]),
         .q_in(c_q[i]), .neg_in(c_neg[i]), .zero_in(c_zero[i]),
         .valid_out(c_valid[i+1]), .s_out(c_s[i+1]), .r_out(c_r[i+1]),
         .b_out(c_b[i+1]), .q_out(c_q[i+1]), .neg_out(c_neg[i+1]),
         .zero_out(c_zero[i+1])
      );
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (c_zero[NC] || (CW'(c_q[NC][k]) < CW'(eps_ff))) begin
            res_in[k] = '0;
         end else if (c_neg[NC][k]) begin
            res_in[k] = OW'(0) - OW'(c_q[NC][k]);
         end else begin
            res_in[k] = OW'(c_q[NC][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= vn_pkg::EPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_tvalid) begin
            eps_ff <= csr_tdata;
         end
         if (advance) begin
            rsp_valid_ff <= c_valid[NC];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
         zv_ff  <= c_zero[NC];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = zv_ff;
   assign rsp_tdata  = ODW'(res_ff);
endmodule

// ===== rtl/vn_prep.sv =====
// Front of the normalizer: magnitudes, squares, sum of squares, start values.
// Depends on vn_pkg (for its parameter defaults).
`timescale 1ns / 1ps

module vn_prep #(
   parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF,
   localparam int SW = 2 * IN_WIDTH,
   localparam int RW = 2 * IN_WIDTH + 2 * FRAC_BITS + 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        valid_in,
   input  logic [2:0][IN_WIDTH-1:0]    comp_in,
   output logic                        valid_out,
   output logic [SW-1:0]               s_out,
   output logic [2:0][RW-1:0]          r_out,
   output logic [2:0]                  neg_out,
   output logic                        zero_out
);
   logic [2:0][IN_WIDTH-1:0] mag;
   logic [2:0][SW-1:0]       sq_ff, sq_in;
   logic [2:0]               nega_ff, nega_in;
   logic                     va_ff;
   logic [SW-1:0]            s_ff, s_in;
   logic [2:0][RW-1:0]       r_ff, r_in;
   logic [2:0]               negb_ff;
   logic                     vb_ff;
   logic                     zero_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nega_in[k] = comp_in[k][IN_WIDTH-1];
         mag[k]     = nega_in[k] ? (~comp_in[k] + IN_WIDTH'(1)) : comp_in[k];
         sq_in[k]   = SW'(mag[k]) * SW'(mag[k]);
      end
      s_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
      for (int k = 0; k < 3; k++) begin
         r_in[k] = RW'(sq_ff[k]) << (2 * FRAC_BITS + 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= valid_in;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff   <= sq_in;
         nega_ff <= nega_in;
         s_ff    <= s_in;
         r_ff    <= r_in;
         negb_ff <= nega_ff;
         zero_ff <= (s_in == '0);
      end
   end

   assign valid_out = vb_ff;
   assign s_out     = s_ff;
   assign r_out     = r_ff;
   assign neg_out   = negb_ff;
   assign zero_out  = zero_ff;
endmodule

// ===== rtl/vn_cell.sv =====
// One cell of the quotient chain: decides bit BIT of all three scaled components.
// Depends on vn_pkg (for its parameter defaults).
`timescale 1ns / 1ps

module vn_cell #(
   parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF,
   parameter int BIT       = 0,
   localparam int SW = 2 * IN_WIDTH,
   localparam int RW = 2 * IN_WIDTH + 2 * FRAC_BITS + 4,
   localparam int QW = FRAC_BITS + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  logic [SW-1:0]        s_in,
   input  logic [2:0][RW-1:0]   r_in,
   input  logic [2:0][RW-1:0]   b_in,
   input  logic [2:0][QW-1:0]   q_in,
   input  logic [2:0]           neg_in,
   input  logic                 zero_in,
   output logic                 valid_out,
   output logic [SW-1:0]        s_out,
   output logic [2:0][RW-1:0]   r_out,
   output logic [2:0][RW-1:0]   b_out,
   output logic [2:0][QW-1:0]   q_out,
   output logic [2:0]           neg_out,
   output logic                 zero_out
);
   logic                valid_ff;
   logic [SW-1:0]       s_ff;
   logic [2:0][RW-1:0]  r_ff, r_nx;
   logic [2:0][RW-1:0]  b_ff, b_nx;
   logic [2:0][QW-1:0]  q_ff, q_nx;
   logic [2:0]          neg_ff;
   logic                zero_ff;
   logic [RW-1:0]       sw, m2s;
   logic [2:0][RW-1:0]  need;
   logic [2:0]          fit;

   always_comb begin
      sw  = RW'(s_in);
      m2s = (sw << (2 * BIT + 2)) - (sw << (BIT + 2)) + sw;
      for (int k = 0; k < 3; k++) begin
         need[k] = (b_in[k] << (BIT + 2)) + m2s;
         fit[k]  = (need[k] <= r_in[k]) && !q_in[k][FRAC_BITS];
         r_nx[k] = fit[k] ? (r_in[k] - need[k] + sw) : r_in[k];
         b_nx[k] = fit[k] ? (b_in[k] + (sw << (BIT + 1))) : b_in[k];
         q_nx[k] = fit[k] ? (q_in[k] | (QW'(1) << BIT)) : q_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff    <= s_in;
         r_ff    <= r_nx;
         b_ff    <= b_nx;
         q_ff    <= q_nx;
         neg_ff  <= neg_in;
         zero_ff <= zero_in;
      end
   end

   assign valid_out = valid_ff;
   assign s_out     = s_ff;
   assign r_out     = r_ff;
   assign b_out     = b_ff;
   assign q_out     = q_ff;
   assign neg_out   = neg_ff;
   assign zero_out  = zero_ff;
endmodule

// ===== rtl/vn_checker.sv =====
// Port-level checks for vector3_normalize_top, bound onto every instance.
// Depends on vn_pkg and vector3_normalize_top_defines.svh.
`timescale 1ns / 1ps
`include "vector3_normalize_top_defines.svh"

module vn_checker #(
   parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF,
   localparam int OW  = FRAC_BITS + 2,
   localparam int ODW = ((3 * OW + 7) / 8) * 8
) (
   input logic           clock,
   input logic           reset,
   input logic           rsp_tvalid,
   input logic           rsp_tready,
   input logic [ODW-1:0] rsp_tdata,
   input logic           rsp_tuser
);
   `VN_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word dropped or changed while stalled")
   `VN_ASSERT_CLK(a_zero_data, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "zero vector word carries nonzero data")
   `VN_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid right after reset")
endmodule

bind vector3_normalize_top vn_checker #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS)) u_vn_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
